// ===== rtl/core/pse_pkg.sv =====
package pse_pkg;

   localparam int DataWidth  = 32;
   localparam int StackDepth = 128;
   localparam int IdxWidth   = $clog2(StackDepth);
   localparam int CntWidth   = $clog2(StackDepth + 1);
   localparam int SymWidth   = 8;
   localparam int StepWidth  = $clog2(DataWidth);

   localparam logic [SymWidth-1:0] CH_ZERO  = 8'h30;
   localparam logic [SymWidth-1:0] CH_NINE  = 8'h39;
   localparam logic [SymWidth-1:0] CH_PLUS  = 8'h2B;
   localparam logic [SymWidth-1:0] CH_MINUS = 8'h2D;
   localparam logic [SymWidth-1:0] CH_STAR  = 8'h2A;
   localparam logic [SymWidth-1:0] CH_SLASH = 8'h2F;
   localparam logic [SymWidth-1:0] CH_CARET = 8'h5E;

   localparam logic [DataWidth-1:0] EMPTY_POP = '1;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_POW = 3'd4;

   typedef struct packed {
      logic       push_digit;
      logic       pop;
      logic       cap_rhs;
      logic       cap_lhs;
      logic       calc_start;
      logic       push_res;
      logic       emit;
      logic [2:0] op;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/pse_ctrl.sv =====
module pse_ctrl
   import pse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SymWidth-1:0] req_tdata,
   input  logic                req_tlast,
   input  status_type          status,
   output cmd_type             cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_POPR  = 4'd1;
   localparam logic [3:0] ST_POPL  = 4'd2;
   localparam logic [3:0] ST_LOADL = 4'd3;
   localparam logic [3:0] ST_CALC  = 4'd4;
   localparam logic [3:0] ST_WAIT  = 4'd5;
   localparam logic [3:0] ST_ENDRD = 4'd6;
   localparam logic [3:0] ST_ENDOUT = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       is_digit;
   logic       is_op;
   logic [2:0] op_dec;

   assign is_digit = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);

   always_comb begin
      is_op  = 1'b1;
      op_dec = OP_ADD;
      unique case (req_tdata)
         CH_PLUS:  op_dec = OP_ADD;
         CH_MINUS: op_dec = OP_SUB;
         CH_STAR:  op_dec = OP_MUL;
         CH_SLASH: op_dec = OP_DIV;
         CH_CARET: op_dec = OP_POW;
         default:  is_op = 1'b0;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tlast) begin
                  state_in = ST_ENDRD;
               end else if (is_digit) begin
                  cmd.push_digit = 1'b1;
               end else if (is_op) begin
                  op_in    = op_dec;
                  state_in = ST_POPR;
               end
            end
         end
         ST_POPR: begin
            cmd.pop  = 1'b1;
            state_in = ST_POPL;
         end
         ST_POPL: begin
            cmd.cap_rhs = 1'b1;
            cmd.pop     = 1'b1;
            state_in    = ST_LOADL;
         end
         ST_LOADL: begin
            cmd.cap_lhs = 1'b1;
            state_in    = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc_start = 1'b1;
            state_in       = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.done) begin
               cmd.push_res = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ENDRD: begin
            cmd.pop  = 1'b1;
            state_in = ST_ENDOUT;
         end
         ST_ENDOUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_ADD;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

// ===== rtl/core/pse_dp.sv =====
module pse_dp
   import pse_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SymWidth-1:0]  req_tdata,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DataWidth-1:0] rsp_tdata,
   output logic                 rsp_tuser
);

   logic [DataWidth-1:0] mem [StackDepth];
   logic [CntWidth-1:0]  cnt_ff;
   logic [DataWidth-1:0] rdata_ff;
   logic                 pop_empty_ff;
   logic [DataWidth-1:0] rhs_ff, lhs_ff, res_ff;
   logic                 done_ff, err_ff;
   // divider
   logic                 div_run_ff, neg_ff;
   logic [DataWidth-1:0] quo_ff, rem_ff, mb_ff;
   logic [StepWidth-1:0] step_ff;
   // power
   logic                 pow_run_ff, phase_ff;
   logic [DataWidth-1:0] base_ff, acc_ff, exp_ff;
   // output
   logic                 out_vld_ff, out_err_ff;
   logic [DataWidth-1:0] out_val_ff;

   logic [DataWidth-1:0]   pop_val, push_val, mul_a, mul_b, quo_nx, rem_nx;
   logic [DataWidth-1:0]   abs_l, abs_r;
   logic [2*DataWidth-1:0] prod;
   logic [DataWidth:0]     shifted, trial;
   logic                   push_en;

   assign pop_val  = pop_empty_ff ? EMPTY_POP : rdata_ff;
   assign push_en  = cmd.push_digit | cmd.push_res;
   assign push_val = cmd.push_digit ?
                     DataWidth'(req_tdata - CH_ZERO) : res_ff;

   assign abs_l = lhs_ff[DataWidth-1] ? (DataWidth'(0) - lhs_ff) : lhs_ff;
   assign abs_r = rhs_ff[DataWidth-1] ? (DataWidth'(0) - rhs_ff) : rhs_ff;

   always_comb begin
      if (cmd.calc_start) begin
         mul_a = lhs_ff;
         mul_b = rhs_ff;
      end else begin
         mul_a = phase_ff ? base_ff : acc_ff;
         mul_b = base_ff;
      end
   end
   assign prod = mul_a * mul_b;

   assign shifted = {rem_ff, quo_ff[DataWidth-1]};
   assign trial   = shifted - {1'b0, mb_ff};
   assign rem_nx  = trial[DataWidth] ? shifted[DataWidth-1:0] : trial[DataWidth-1:0];
   assign quo_nx  = {quo_ff[DataWidth-2:0], ~trial[DataWidth]};

   always_ff @(posedge clock) begin
      if (push_en && (cnt_ff < CntWidth'(StackDepth))) begin
         mem[cnt_ff[IdxWidth-1:0]] <= push_val;
      end
      if (cmd.pop && (cnt_ff != '0)) begin
         rdata_ff <= mem[IdxWidth'(cnt_ff - 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         err_ff     <= 1'b0;
         done_ff    <= 1'b0;
         div_run_ff <= 1'b0;
         pow_run_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (push_en && (cnt_ff < CntWidth'(StackDepth))) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.pop && (cnt_ff != '0)) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (out_vld_ff && rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         if (cmd.emit) begin
            out_vld_ff <= 1'b1;
            cnt_ff     <= '0;
            err_ff     <= 1'b0;
         end
         if (cmd.calc_start) begin
            done_ff <= 1'b0;
            unique case (cmd.op)
               OP_ADD, OP_SUB, OP_MUL: done_ff <= 1'b1;
               OP_DIV: begin
                  if (rhs_ff == '0) begin
                     err_ff  <= 1'b1;
                     done_ff <= 1'b1;
                  end else begin
                     div_run_ff <= 1'b1;
                  end
               end
               OP_POW: begin
                  if (rhs_ff[DataWidth-1] || (rhs_ff == '0)) begin
                     done_ff <= 1'b1;
                  end else begin
                     pow_run_ff <= 1'b1;
                  end
               end
               default: done_ff <= 1'b1;
            endcase
         end
         if (div_run_ff && (step_ff == StepWidth'(DataWidth - 1))) begin
            div_run_ff <= 1'b0;
            done_ff    <= 1'b1;
         end
         if (pow_run_ff && !phase_ff && (exp_ff == '0)) begin
            pow_run_ff <= 1'b0;
            done_ff    <= 1'b1;
         end
      end
   end

   // operand capture, arithmetic payload
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         pop_empty_ff <= (cnt_ff == '0);
      end
      if (cmd.cap_rhs) begin
         rhs_ff <= pop_val;
      end
      if (cmd.cap_lhs) begin
         lhs_ff <= pop_val;
      end
      if (cmd.emit) begin
         out_val_ff <= pop_val;
         out_err_ff <= err_ff;
      end
      if (cmd.calc_start) begin
         unique case (cmd.op)
            OP_ADD: res_ff <= lhs_ff + rhs_ff;
            OP_SUB: res_ff <= lhs_ff - rhs_ff;
            OP_MUL: res_ff <= prod[DataWidth-1:0];
            OP_DIV: begin
               res_ff  <= '0;
               quo_ff  <= abs_l;
               mb_ff   <= abs_r;
               rem_ff  <= '0;
               neg_ff  <= lhs_ff[DataWidth-1] ^ rhs_ff[DataWidth-1];
               step_ff <= '0;
            end
            OP_POW: begin
               res_ff   <= DataWidth'(1);
               acc_ff   <= DataWidth'(1);
               base_ff  <= lhs_ff;
               exp_ff   <= rhs_ff;
               phase_ff <= 1'b0;
            end
            default: res_ff <= '0;
         endcase
      end
      if (div_run_ff) begin
         quo_ff  <= quo_nx;
         rem_ff  <= rem_nx;
         step_ff <= step_ff + 1'b1;
         if (step_ff == StepWidth'(DataWidth - 1)) begin
            res_ff <= neg_ff ? (DataWidth'(0) - quo_nx) : quo_nx;
         end
      end
      if (pow_run_ff) begin
         if (!phase_ff) begin
            if (exp_ff == '0) begin
               res_ff <= acc_ff;
            end else begin
               if (exp_ff[0]) begin
                  acc_ff <= prod[DataWidth-1:0];
               end
               phase_ff <= 1'b1;
            end
         end else begin
            base_ff  <= prod[DataWidth-1:0];
            exp_ff   <= exp_ff >> 1;
            phase_ff <= 1'b0;
         end
      end
   end

   assign status.done     = done_ff;
   assign status.out_free = !out_vld_ff || rsp_tready;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_val_ff;
   assign rsp_tuser  = out_err_ff;

endmodule

// ===== rtl/core/postfix_stack_evaluator_unit.sv =====
// Postfix evaluator: one character item per request, one result per end item.
// Digits are pushed, ignored characters dropped; + - * compute directly; /
// runs a 32-step restoring divider; ^ uses square-and-multiply, a multiply
// and a square per exponent bit on one shared 32x32 multiplier. End items pop and emit.
// Reset (synchronous, high) empties the stack and clears the error flag;
// stack memory contents are not cleared and need no clearing pass.
module postfix_stack_evaluator_unit
   import pse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tlast,   // end_of_expression
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value (signed)
   output logic        rsp_tuser    // [0] divide_by_zero
);

   cmd_type    cmd;
   status_type status;

   // sequencer: decodes the item, steps pops, compute and push
   pse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   // stack memory, operand registers, divider, power unit, output register
   pse_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import pse_pkg::*;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } char_item_t;

   typedef struct packed {
      logic [31:0] value;
      logic        div_zero;
   } result_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] symbol
   logic        req_tlast;   // end_of_expression
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] value
   logic        rsp_tuser;   // [0] divide_by_zero

   postfix_stack_evaluator_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   char_item_t  pending_chars[$];
   result_t     expected_results[$];
   logic [31:0] eval_stack[StackDepth];
   int          eval_depth;
   logic        eval_div_err;
   int          error_count;
   int          send_gap;
   int          recv_gap;
   bit          hold_sender;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("tb: mismatch %s got %h want %h", what, got, want);
      error_count++;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] eval_pop();
      if (eval_depth == 0) return EMPTY_POP;
      eval_depth--;
      return eval_stack[eval_depth];
   endfunction

   function automatic void eval_push(input logic [31:0] v);
      if (eval_depth < StackDepth) begin
         eval_stack[eval_depth] = v;
         eval_depth++;
      end
   endfunction

   function automatic logic [31:0] signed_quot(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma, mb, q;
      if (b == 0) begin
         eval_div_err = 1'b1;
         return 32'd0;
      end
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic logic [31:0] int_power(input logic [31:0] base, input logic [31:0] e);
      logic [31:0] r;
      r = 32'd1;
      if (e[31]) return r;
      while (e != 0) begin
         if (e[0]) r = r * base;
         base = base * base;
         e = e >> 1;
      end
      return r;
   endfunction

   // Track one accepted character; terminators queue the expected result.
   function automatic void evaluate_char(input char_item_t c);
      logic [31:0] rhs, lhs, r;
      if (c.last) begin
         expected_results.push_back('{value: eval_pop(), div_zero: eval_div_err});
         eval_depth = 0;
         eval_div_err = 1'b0;
      end else if (c.symbol >= CH_ZERO && c.symbol <= CH_NINE) begin
         eval_push({24'd0, c.symbol - CH_ZERO});
      end else if (c.symbol inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET}) begin
         rhs = eval_pop();
         lhs = eval_pop();
         case (c.symbol)
            CH_PLUS:  r = lhs + rhs;
            CH_MINUS: r = lhs - rhs;
            CH_STAR:  r = lhs * rhs;
            CH_SLASH: r = signed_quot(lhs, rhs);
            default:  r = int_power(lhs, rhs);
         endcase
         eval_push(r);
      end
   endfunction

   function automatic void add_char(input logic [7:0] s, input logic l);
      pending_chars.push_back('{symbol: s, last: l});
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i], 1'b0);
      add_char(8'h00, 1'b1);
   endfunction

   function automatic logic [7:0] random_op();
      case ($urandom_range(0, 4))
         0: return CH_PLUS;
         1: return CH_MINUS;
         2: return CH_STAR;
         3: return CH_SLASH;
         default: return CH_CARET;
      endcase
   endfunction

   // Well-formed postfix with random content, plus occasional noise.
   function automatic void add_random_expr(input int nops);
      int depth;
      depth = 0;
      for (int k = 0; k < 2 * nops + 1; k++) begin
         if ($urandom_range(0, 15) == 0) add_char(8'($urandom_range(0, 255)), 1'b0);
         if (depth >= 2 && ($urandom_range(0, 1) || k >= nops + depth - 1)) begin
            add_char(random_op(), 1'b0);
            depth--;
         end else begin
            add_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            depth++;
         end
      end
      add_char(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0 || hold_sender || pending_chars.size() == 0) begin
            req_tvalid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end else begin
            req_tvalid <= 1'b1;
            {req_tdata, req_tlast} <= pending_chars.pop_front();
            send_gap <= gap_len();
         end
      end
   end

   // Predictor fed at acceptance
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) evaluate_char('{req_tdata, req_tlast});
   end

   // Monitor and result stall
   always @(posedge clock) begin
      result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.value) report_mismatch("value", rsp_tdata, want.value);
               if (rsp_tuser !== want.div_zero)
                  report_mismatch("divide_by_zero", rsp_tuser, want.div_zero);
            end
         end
         if (recv_gap > 0) begin
            rsp_tready <= 1'b0;
            recv_gap <= recv_gap - 1;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap <= gap_len();
         end
      end
   end

   initial begin
      int n;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      error_count = 0;
      eval_depth = 0;
      eval_div_err = 1'b0;
      hold_sender = 1'b0;

      // directed: every operator, empty pops, div by zero, overflow cases, noise
      add_text("34+");
      add_text("93-");
      add_text("78*");
      add_text("72-/");
      add_text("30/");
      add_text("2 0-^x");
      add_text("23^");
      add_text("+");
      add_text("");
      add_char(8'hFF, 1'b0);
      add_char(8'h00, 1'b0);
      add_char(CH_NINE, 1'b0);
      add_char(8'hA5, 1'b1);
      add_text("09-1-9-9*9*9*9*9*9*9*9*9*9*9*");
      add_text("29^9^");
      add_text("01-01-01-01-01-01-01-01-2^^^^^^^^/");
      repeat (StackDepth + 3) add_char(CH_NINE, 1'b0);   // overfill the stack
      add_char(CH_PLUS, 1'b0);
      add_char(8'h5A, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() > 0) @(posedge clock);
      // drain completely before continuing
      hold_sender = 1'b1;
      while (expected_results.size() > 0 || req_tvalid) @(posedge clock);
      hold_sender = 1'b0;

      n = 0;
      while (n < 1500) begin
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)), 1'b0);
            add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            add_random_expr($urandom_range(0, 8));
         end
         n = n + pending_chars.size();
         while (pending_chars.size() > 0) @(posedge clock);
      end
      while (req_tvalid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pse_pkg.sv
rtl/core/pse_ctrl.sv
rtl/core/pse_dp.sv
rtl/core/postfix_stack_evaluator_unit.sv
sim/tb.sv
